FILE: sv/voltage_request_level_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Voltage request level arbiter - assertion macros
// Shared property forms used by the arbiter's checks.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_REQUEST_LEVEL_ARBITER_DEFINES_SVH
`define VOLTAGE_REQUEST_LEVEL_ARBITER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define VRLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, reset masks the check
`define VRLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: sv/vrla_pkg.sv
// ----------------------------------------------------------------------------
// Voltage request level arbiter - package
// Word types, register indexes, reset values and shared helpers.
// ----------------------------------------------------------------------------
package vrla_pkg;

	localparam int unsigned DEF_NUM_LEVELS     = 3;
	localparam int unsigned DEF_NUM_REQUESTERS = 8;
	localparam int unsigned MAX_LEVELS         = 3;

	localparam int unsigned KIND_W    = 2;
	localparam int unsigned REQ_W     = 4;
	localparam int unsigned MV_W      = 16;
	localparam int unsigned LEVEL_W   = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [KIND_W-1:0] KIND_ADJUST    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FORCE_LOW = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REINIT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_MV      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_MV      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_MV      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_HIGH_VALUE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_LOW_VALUE  = 3'd5;

	localparam logic [MV_W-1:0]    LEVEL0_MV_RST      = 16'd5000;
	localparam logic [MV_W-1:0]    LEVEL1_MV_RST      = 16'd12000;
	localparam logic [MV_W-1:0]    LEVEL2_MV_RST      = 16'd20000;
	localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL_RST  = 2'd0;
	localparam logic               PIN_HIGH_VALUE_RST = 1'b1;
	localparam logic               PIN_LOW_VALUE_RST  = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [REQ_W-1:0]  requester;
		logic [MV_W-1:0]   need_mv;
	} adj_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               pin_b0;
		logic               pin_b1;
		logic               level_changed;
		logic               bad_requester;
	} res_word_t;

	typedef struct packed {
		logic [MAX_LEVELS-1:0][MV_W-1:0] level_mv;
		logic [LEVEL_W-1:0]              default_level;
		logic                            pin_high_value;
		logic                            pin_low_value;
	} cfg_t;

	// saturate a level code to the top built level
	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv,
		input int unsigned n);
		logic [LEVEL_W-1:0] res;
		if (int'(lv) >= int'(n)) begin
			res = LEVEL_W'(n - 1);
		end else begin
			res = lv;
		end
		return res;
	endfunction

endpackage

FILE: sv/vrla_cfg.sv
// ----------------------------------------------------------------------------
// Voltage request level arbiter - configuration registers
// Holds level voltages, default level and pin polarity.
// ----------------------------------------------------------------------------
module vrla_cfg
	import vrla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_mv[0]    <= LEVEL0_MV_RST;
			cfg_q.level_mv[1]    <= LEVEL1_MV_RST;
			cfg_q.level_mv[2]    <= LEVEL2_MV_RST;
			cfg_q.default_level  <= DEFAULT_LEVEL_RST;
			cfg_q.pin_high_value <= PIN_HIGH_VALUE_RST;
			cfg_q.pin_low_value  <= PIN_LOW_VALUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL0_MV:      cfg_q.level_mv[0]    <= cfg_data[MV_W-1:0];
				CFG_LEVEL1_MV:      cfg_q.level_mv[1]    <= cfg_data[MV_W-1:0];
				CFG_LEVEL2_MV:      cfg_q.level_mv[2]    <= cfg_data[MV_W-1:0];
				CFG_DEFAULT_LEVEL:  cfg_q.default_level  <= cfg_data[LEVEL_W-1:0];
				CFG_PIN_HIGH_VALUE: cfg_q.pin_high_value <= cfg_data[0];
				CFG_PIN_LOW_VALUE:  cfg_q.pin_low_value  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: sv/vrla_core.sv
// ----------------------------------------------------------------------------
// Voltage request level arbiter - arbitration core
// Holds the per-level requester bitmaps and the selected level, and works
// out the next state and the result word for the staged item.
// ----------------------------------------------------------------------------
module vrla_core
	import vrla_pkg::*;
#(
	parameter int unsigned NUM_LEVELS     = DEF_NUM_LEVELS,
	parameter int unsigned NUM_REQUESTERS = DEF_NUM_REQUESTERS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  adj_word_t adj,
	input  cfg_t      cfg,
	output res_word_t res
);

	logic [NUM_LEVELS-1:0][NUM_REQUESTERS-1:0] map_q;
	logic [NUM_LEVELS-1:0][NUM_REQUESTERS-1:0] map_d;
	logic [LEVEL_W-1:0]                        level_q;
	logic [LEVEL_W-1:0]                        level_d;

	always_comb begin
		logic [LEVEL_W-1:0]        target;
		logic [NUM_REQUESTERS-1:0] bit_sel;
		logic                      req_ok;
		map_d   = map_q;
		level_d = level_q;
		target  = LEVEL_W'(NUM_LEVELS - 1);
		bit_sel = '0;
		req_ok  = (adj.requester < REQ_W'(NUM_REQUESTERS));
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (adj.need_mv <= cfg.level_mv[i]) begin
				target = LEVEL_W'(i);
			end
		end
		for (int j = 0; j < NUM_REQUESTERS; j++) begin
			bit_sel[j] = (adj.requester == REQ_W'(j));
		end
		case (adj.kind)
			KIND_ADJUST: begin
				if (req_ok) begin
					for (int i = 0; i < NUM_LEVELS; i++) begin
						if (target == LEVEL_W'(i)) begin
							map_d[i] = map_q[i] | bit_sel;
						end else begin
							map_d[i] = map_q[i] & ~bit_sel;
						end
					end
					for (int i = 0; i < NUM_LEVELS; i++) begin
						if (map_d[i] != '0) begin
							level_d = LEVEL_W'(i);
						end
					end
				end
			end
			KIND_FORCE_LOW: begin
				map_d   = '0;
				level_d = '0;
			end
			KIND_REINIT: begin
				map_d   = '0;
				level_d = clamp_level(cfg.default_level, NUM_LEVELS);
			end
			default: begin
			end
		endcase
		res.level         = level_d;
		res.pin_b0        = level_d[0] ? cfg.pin_high_value : cfg.pin_low_value;
		res.pin_b1        = (NUM_LEVELS > 2) ?
			(level_d[1] ? cfg.pin_high_value : cfg.pin_low_value) : 1'b0;
		res.level_changed = (level_d != level_q);
		res.bad_requester = (adj.kind == KIND_ADJUST) && !req_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= '0;
			level_q <= clamp_level(DEFAULT_LEVEL_RST, NUM_LEVELS);
		end else if (en) begin
			map_q   <= map_d;
			level_q <= level_d;
		end
	end

endmodule

FILE: sv/voltage_request_level_arbiter.sv
// ----------------------------------------------------------------------------
// Voltage request level arbiter - top level
// Selects a supply level from per-requester millivolt needs.
//
// Adjust channel: adj_valid / adj_stall carry one adj_word per accepted word
//   (adjust, force low or reinit to default).
// Result channel: res_valid / res_stall return exactly one res_word for each
//   accepted adj_word, in order.
// Config channel: cfg_valid / cfg_ready write cfg_data to register cfg_index;
//   cfg_ready is always high. Write only while no word is in flight.
// Path: an accepted word is registered in the input register; its result
//   is worked out from there and registered in the result register.
// Throughput: one word per cycle while res_stall is low; the input register
//   and the result register form a two-deep pipeline and the state updates
//   on the move between them.
// Stall: while res_stall holds a waiting result, the staged word waits and
//   adj_stall rises only when the input register is full as well.
// Reset: bitmaps clear, the level takes the reset default, both stages empty.
// ----------------------------------------------------------------------------
`include "voltage_request_level_arbiter_defines.svh"

module voltage_request_level_arbiter
	import vrla_pkg::*;
#(
	parameter int unsigned NUM_LEVELS     = DEF_NUM_LEVELS,
	parameter int unsigned NUM_REQUESTERS = DEF_NUM_REQUESTERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adj_valid,
	output logic                 adj_stall,
	input  adj_word_t            adj_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_word_t            res_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t      cfg;
	adj_word_t adj_s1;
	logic      adj_valid_s1;
	res_word_t res_d;
	res_word_t res_s2;
	logic      res_valid_s2;
	logic      advance;

	assign advance   = adj_valid_s1 && (!res_valid_s2 || !res_stall);
	assign adj_stall = adj_valid_s1 && !advance;
	assign res_valid = res_valid_s2;
	assign res_word  = res_s2;

	vrla_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vrla_core #(
		.NUM_LEVELS     (NUM_LEVELS),
		.NUM_REQUESTERS (NUM_REQUESTERS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.adj    (adj_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// hold words while the stage ahead is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (!adj_stall) begin
				adj_valid_s1 <= adj_valid;
			end
			if (!res_valid_s2 || !res_stall) begin
				res_valid_s2 <= adj_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adj_valid && !adj_stall) begin
			adj_s1 <= adj_word;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	`VRLA_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, adj_valid && !adj_stall, adj_valid_s1)
	`VRLA_ASSERT_IMPLY(a_level_in_range, clk, arst_n, res_valid_s2,
		int'(res_s2.level) < int'(NUM_LEVELS))
	`VRLA_ASSERT_IMPLY(a_bad_keeps_level, clk, arst_n, res_valid_s2 && res_s2.bad_requester,
		!res_s2.level_changed)

endmodule

FILE: sim/voltage_request_level_arbiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voltage request level arbiter - testbench
// Drives adjust, force-low, reinit and unused-kind words with random gaps on
// both channels and rewrites the level, default and pin-polarity registers
// between phases. Each result word is checked field by field against a directed
// row's listed word or a model of the requester bitmaps and the selected level.
// ----------------------------------------------------------------------------
module voltage_request_level_arbiter_tb
	import vrla_pkg::*;
();

	localparam int unsigned N_LEVELS = DEF_NUM_LEVELS;
	localparam int unsigned N_REQ    = DEF_NUM_REQUESTERS;
	localparam logic [KIND_W-1:0]    KIND_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;
	localparam int unsigned          RX_HOLD_CYCLES = 60;
	localparam int unsigned          PHASES         = 8;
	localparam int unsigned          PHASE_WORDS    = 80;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
		adj_word_t            w;
		bit                   typed;
		res_word_t            want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 adj_valid;
	logic                 adj_stall;
	adj_word_t            adj_word;
	logic                 res_valid;
	logic                 res_stall;
	res_word_t            res_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// model state and register copy
	logic [MV_W-1:0]    set_mv [MAX_LEVELS];
	logic [LEVEL_W-1:0] set_default;
	logic               set_pin_hi;
	logic               set_pin_lo;
	logic [7:0]         lvl_map [MAX_LEVELS];
	logic [LEVEL_W-1:0] sel_level;

	res_word_t   level_results [$];
	dir_row_t    dir_rows [$];
	bit          cur_typed;
	res_word_t   cur_want;
	bit          hold_off_req;
	int unsigned mismatch_count;

	voltage_request_level_arbiter #(
		.NUM_LEVELS     (N_LEVELS),
		.NUM_REQUESTERS (N_REQ)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.adj_valid (adj_valid),
		.adj_stall (adj_stall),
		.adj_word  (adj_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic res_word_t arbitrate(input adj_word_t w);
		res_word_t          r;
		logic [LEVEL_W-1:0] prior;
		logic [LEVEL_W-1:0] target;
		logic [7:0]         req_bit;
		int                 i;
		r = '0;
		prior = sel_level;
		case (w.kind)
			KIND_ADJUST: begin
				if (w.requester >= N_REQ) begin
					r.bad_requester = 1'b1;
				end else begin
					target = LEVEL_W'(N_LEVELS - 1);
					for (i = N_LEVELS - 1; i >= 0; i--)
						if (w.need_mv <= set_mv[i])
							target = LEVEL_W'(i);
					req_bit = 8'd1 << w.requester;
					for (i = 0; i < N_LEVELS; i++)
						lvl_map[i] = (i == target) ? (lvl_map[i] | req_bit) :
							(lvl_map[i] & ~req_bit);
					for (i = 0; i < N_LEVELS; i++)
						if (lvl_map[i] != 8'd0)
							sel_level = LEVEL_W'(i);
				end
			end
			KIND_FORCE_LOW: begin
				for (i = 0; i < MAX_LEVELS; i++)
					lvl_map[i] = 8'd0;
				sel_level = '0;
			end
			KIND_REINIT: begin
				for (i = 0; i < MAX_LEVELS; i++)
					lvl_map[i] = 8'd0;
				sel_level = (set_default >= N_LEVELS) ? LEVEL_W'(N_LEVELS - 1) : set_default;
			end
			default: ;
		endcase
		r.level = sel_level;
		r.pin_b0 = sel_level[0] ? set_pin_hi : set_pin_lo;
		r.pin_b1 = (N_LEVELS > 2) ? (sel_level[1] ? set_pin_hi : set_pin_lo) : 1'b0;
		r.level_changed = (sel_level != prior);
		return r;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		case (idx)
			CFG_LEVEL0_MV:      set_mv[0] = data;
			CFG_LEVEL1_MV:      set_mv[1] = data;
			CFG_LEVEL2_MV:      set_mv[2] = data;
			CFG_DEFAULT_LEVEL:  set_default = data[LEVEL_W-1:0];
			CFG_PIN_HIGH_VALUE: set_pin_hi = data[0];
			CFG_PIN_LOW_VALUE:  set_pin_lo = data[0];
			default: ;
		endcase
	endfunction

	// check leaving words first, then log the arriving word and any register write
	always @(posedge clk) begin
		res_word_t want;
		res_word_t got;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got = res_word;
				if (level_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result word with none expected: lvl %0d pins %b%b chg %b bad %b",
							$realtime, got.level, got.pin_b1, got.pin_b0,
							got.level_changed, got.bad_requester);
					mismatch_count++;
				end else begin
					want = level_results.pop_front();
					if (got.level !== want.level || got.pin_b0 !== want.pin_b0 ||
						got.pin_b1 !== want.pin_b1 ||
						got.level_changed !== want.level_changed ||
						got.bad_requester !== want.bad_requester) begin
						if (mismatch_count < 10)
							$display("%0t: mismatch lvl %0d/%0d pin0 %b/%b pin1 %b/%b chg %b/%b bad %b/%b (exp/got)",
								$realtime, want.level, got.level, want.pin_b0,
								got.pin_b0, want.pin_b1, got.pin_b1,
								want.level_changed, got.level_changed,
								want.bad_requester, got.bad_requester);
						mismatch_count++;
					end
				end
			end
			if (adj_valid && !adj_stall) begin
				got = arbitrate(adj_word);
				level_results.push_back(cur_typed ? cur_want : got);
			end
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// receiver: short and long stalls, quiet stretches, and the requested hold-off
	initial begin
		int unsigned stall_left;
		int unsigned open_left;
		stall_left = 0;
		open_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_stall = 1'b1;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				res_stall = 1'b0;
			end else if (stall_left != 0) begin
				res_stall = 1'b1;
				stall_left--;
			end else begin
				res_stall = 1'b0;
				if (open_left != 0) begin
					open_left--;
				end else begin
					open_left = ($urandom_range(0, 19) == 0) ? 80 : $urandom_range(0, 6);
					stall_left = idle_len();
				end
			end
		end
	end

	task automatic send_word(input adj_word_t w, input bit typed, input res_word_t want);
		adj_valid = 1'b1;
		adj_word = w;
		cur_typed = typed;
		cur_want = want;
		@(posedge clk);
		while (adj_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		adj_valid = 1'b0;
		while (level_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [MV_W-1:0] pick_mv(input logic [MV_W-1:0] floor_mv);
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return MV_W'($urandom());
		v = floor_mv + $urandom_range(0, 20000);
		return (v > 65535) ? '1 : MV_W'(v);
	endfunction

	// all-high, all-low, then random register sets
	task automatic write_settings(input int unsigned ph);
		logic [MV_W-1:0] a;
		logic [MV_W-1:0] b;
		logic [MV_W-1:0] c;
		if (ph == 0) begin
			write_reg(CFG_LEVEL0_MV, '1);
			write_reg(CFG_LEVEL1_MV, '1);
			write_reg(CFG_LEVEL2_MV, '1);
			write_reg(CFG_DEFAULT_LEVEL, 16'd2);
			write_reg(CFG_PIN_HIGH_VALUE, 16'd1);
			write_reg(CFG_PIN_LOW_VALUE, 16'd1);
		end else if (ph == 1) begin
			write_reg(CFG_LEVEL0_MV, '0);
			write_reg(CFG_LEVEL1_MV, '0);
			write_reg(CFG_LEVEL2_MV, '0);
			write_reg(CFG_DEFAULT_LEVEL, '0);
			write_reg(CFG_PIN_HIGH_VALUE, '0);
			write_reg(CFG_PIN_LOW_VALUE, '0);
		end else begin
			a = pick_mv(MV_W'($urandom_range(0, 8000)));
			b = pick_mv(a);
			c = pick_mv(b);
			write_reg(CFG_LEVEL0_MV, a);
			write_reg(CFG_LEVEL1_MV, b);
			write_reg(CFG_LEVEL2_MV, c);
			write_reg(CFG_DEFAULT_LEVEL, {14'($urandom()), 2'($urandom_range(0, 3))});
			write_reg(CFG_PIN_HIGH_VALUE, {15'($urandom()), 1'($urandom_range(0, 1))});
			write_reg(CFG_PIN_LOW_VALUE, {15'($urandom()), 1'($urandom_range(0, 1))});
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom()));
		end
		cfg_valid = 1'b0;
	endtask

	function automatic adj_word_t random_word();
		adj_word_t   w;
		int unsigned r;
		int unsigned lv;
		r = $urandom_range(0, 99);
		if (r < 70)
			w.kind = KIND_ADJUST;
		else if (r < 80)
			w.kind = KIND_FORCE_LOW;
		else if (r < 90)
			w.kind = KIND_REINIT;
		else
			w.kind = KIND_UNUSED;
		w.requester = ($urandom_range(0, 9) == 0) ? REQ_W'($urandom_range(8, 15)) :
			REQ_W'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: w.need_mv = '0;
			1: w.need_mv = '1;
			2, 3: w.need_mv = MV_W'($urandom());
			default: begin
				lv = $urandom_range(0, N_LEVELS - 1);
				w.need_mv = set_mv[lv] + MV_W'($urandom_range(0, 2)) - MV_W'(1);
			end
		endcase
		return w;
	endfunction

	function automatic void add_adj(input logic [KIND_W-1:0] kind, input int unsigned req,
		input int unsigned mv);
		dir_row_t row;
		row = '{default: '0};
		row.w = '{kind: kind, requester: REQ_W'(req), need_mv: MV_W'(mv)};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_chk(input logic [KIND_W-1:0] kind, input int unsigned req,
		input int unsigned mv, input int unsigned lvl, input bit p0, input bit p1,
		input bit chg, input bit bad);
		dir_row_t row;
		row = '{default: '0};
		row.w = '{kind: kind, requester: REQ_W'(req), need_mv: MV_W'(mv)};
		row.typed = 1'b1;
		row.want = '{level: LEVEL_W'(lvl), pin_b0: p0, pin_b1: p1,
			level_changed: chg, bad_requester: bad};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		dir_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = CFG_DAT_W'(data);
		dir_rows.push_back(row);
	endfunction

	initial begin
		int unsigned gap;
		int unsigned i;
		int unsigned ph;
		int unsigned n;
		adj_word_t   w;
		arst_n = 1'b0;
		adj_valid = 1'b0;
		adj_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		hold_off_req = 1'b0;
		mismatch_count = 0;
		set_mv[0] = LEVEL0_MV_RST;
		set_mv[1] = LEVEL1_MV_RST;
		set_mv[2] = LEVEL2_MV_RST;
		set_default = DEFAULT_LEVEL_RST;
		set_pin_hi = PIN_HIGH_VALUE_RST;
		set_pin_lo = PIN_LOW_VALUE_RST;
		for (i = 0; i < MAX_LEVELS; i++)
			lvl_map[i] = 8'd0;
		sel_level = DEFAULT_LEVEL_RST;

		// reset values: 5000 / 12000 / 20000 mV, default 0, pins active high
		add_chk(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0);
		add_chk(KIND_ADJUST, 0, 0, 0, 0, 0, 0, 0);
		add_chk(KIND_ADJUST, 7, 5001, 1, 1, 0, 1, 0);
		add_chk(KIND_ADJUST, 3, 65535, 2, 0, 1, 1, 0);
		add_chk(KIND_ADJUST, 15, 65535, 2, 0, 1, 0, 1);
		add_chk(KIND_ADJUST, 8, 0, 2, 0, 1, 0, 1);
		add_chk(KIND_ADJUST, 3, 12000, 1, 1, 0, 1, 0);
		add_chk(KIND_ADJUST, 7, 5000, 1, 1, 0, 0, 0);
		add_chk(KIND_ADJUST, 3, 20000, 2, 0, 1, 1, 0);
		add_chk(KIND_FORCE_LOW, 15, 65535, 0, 0, 0, 1, 0);
		add_chk(KIND_FORCE_LOW, 0, 0, 0, 0, 0, 0, 0);
		add_chk(KIND_ADJUST, 0, 1, 0, 0, 0, 0, 0);
		add_chk(KIND_ADJUST, 5, 20001, 2, 0, 1, 1, 0);
		add_chk(KIND_REINIT, 9, 43690, 0, 0, 0, 1, 0);
		add_chk(KIND_UNUSED, 15, 65535, 0, 0, 0, 0, 0);
		add_chk(KIND_ADJUST, 1, 12001, 2, 0, 1, 1, 0);
		add_chk(KIND_UNUSED, 6, 21845, 2, 0, 1, 0, 0);
		add_adj(KIND_ADJUST, 2, 43690);
		add_adj(KIND_ADJUST, 6, 21845);
		add_adj(KIND_ADJUST, 4, 11999);
		// inverted pins, out-of-range default, unordered levels, spare indexes
		add_cfg(CFG_LEVEL0_MV, 0);
		add_cfg(CFG_LEVEL1_MV, 65535);
		add_cfg(CFG_LEVEL2_MV, 0);
		add_cfg(CFG_DEFAULT_LEVEL, 3);
		add_cfg(CFG_PIN_HIGH_VALUE, 0);
		add_cfg(CFG_PIN_LOW_VALUE, 1);
		add_cfg(CFG_SPARE_LO, 65535);
		add_cfg(CFG_SPARE_HI, 0);
		add_adj(KIND_REINIT, 0, 0);
		add_chk(KIND_REINIT, 0, 0, 2, 1, 0, 0, 0);
		add_chk(KIND_ADJUST, 0, 0, 0, 1, 1, 1, 0);
		add_chk(KIND_ADJUST, 1, 1, 1, 0, 1, 1, 0);
		add_chk(KIND_ADJUST, 2, 65535, 1, 0, 1, 0, 0);
		add_chk(KIND_FORCE_LOW, 1, 1, 0, 1, 1, 1, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				drain();
				write_reg(dir_rows[k].idx, dir_rows[k].data);
				cfg_valid = 1'b0;
			end else begin
				send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
				gap = idle_len();
				if (gap != 0) begin
					adj_valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			write_settings(ph);
			n = PHASE_WORDS;
			for (i = 0; i < n; i++) begin
				// fill the pipe against a held-off receiver
				if ((ph == 2 || ph == 5) && i == 10)
					hold_off_req = 1'b1;
				if (ph == 3 && i == 40)
					drain();
				w = random_word();
				send_word(w, 1'b0, '0);
				gap = (i >= 30 && i < 50) ? 0 : idle_len();
				if (hold_off_req)
					gap = 0;
				if (gap != 0) begin
					adj_valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0 && level_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/vrla_pkg.sv
sv/vrla_cfg.sv
sv/vrla_core.sv
sv/voltage_request_level_arbiter.sv
sim/voltage_request_level_arbiter_tb.sv
